// ===== design/sccbwm_pkg.sv =====
// ----------------------------------------------------------------------------
// SCCB write master package
// Phase codes, register indexes and the per-tick pin/status result type.
// ----------------------------------------------------------------------------
package sccbwm_pkg;

    localparam int PHASE_W = 5;

    localparam logic [PHASE_W-1:0] PH_IDLE    = 5'd0;
    localparam logic [PHASE_W-1:0] PH_ST_HIGH = 5'd1;
    localparam logic [PHASE_W-1:0] PH_ST_FALL = 5'd2;
    localparam logic [PHASE_W-1:0] PH_ST_LOW  = 5'd3;
    localparam logic [PHASE_W-1:0] PH_ST_PAD  = 5'd4;
    localparam logic [PHASE_W-1:0] PH_B_SET   = 5'd5;
    localparam logic [PHASE_W-1:0] PH_B_HIGH  = 5'd6;
    localparam logic [PHASE_W-1:0] PH_B_LOW   = 5'd7;
    localparam logic [PHASE_W-1:0] PH_A_SET   = 5'd8;
    localparam logic [PHASE_W-1:0] PH_A_HIGH  = 5'd9;
    localparam logic [PHASE_W-1:0] PH_A_LOW   = 5'd10;
    localparam logic [PHASE_W-1:0] PH_A_PAD   = 5'd11;
    localparam logic [PHASE_W-1:0] PH_END_PAD = 5'd12;
    localparam logic [PHASE_W-1:0] PH_P_LOW   = 5'd13;
    localparam logic [PHASE_W-1:0] PH_P_HIGH  = 5'd14;
    localparam logic [PHASE_W-1:0] PH_P_RISE  = 5'd15;
    localparam logic [PHASE_W-1:0] PH_P_PAD   = 5'd16;

    // ninth-bit outcome, kept in the bit index
    localparam logic [3:0] ACKED_MARK  = 4'd8;
    localparam logic [3:0] NACKED_MARK = 4'd9;
    localparam logic [3:0] LAST_BIT    = 4'd7;

    localparam logic [1:0] BYTE_DEV  = 2'd0;
    localparam logic [1:0] BYTE_ADDR = 2'd1;
    localparam logic [1:0] BYTE_DATA = 2'd2;

    localparam logic CFG_DEVICE_ADDRESS = 1'b0;
    localparam logic CFG_UNIT_TICKS     = 1'b1;

    localparam logic [7:0]  DEVICE_ADDRESS_RST = 8'h42;
    localparam logic [15:0] UNIT_TICKS_RST     = 16'd100;

    typedef struct packed {
        logic nack;
        logic done_res;
        logic busy_res;
        logic sda_drive;
        logic sda_out;
        logic scl;
    } tick_res_t;

endpackage

// ===== design/sccb_register_write_master_top.sv =====
// ----------------------------------------------------------------------------
// SCCB register write master
// Tick-level SCCB three-byte write master with stream handshake.
// ----------------------------------------------------------------------------
// Each input transfer is one bus tick and yields exactly one output transfer
// with that tick's SCL/SDA levels and status. A transfer is taken every clock
// cycle unless the output register is full and m_tready is low; its result
// appears in the output register in the next cycle, and the input side keeps
// accepting while that register is emptied in the same cycle. The rate of one
// tick per cycle is set by the single phase state register update per transfer.
module sccb_register_write_master_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // reg_addr[7:0], reg_data[15:8], sda_in[16], zero pad
    input  logic        s_tuser,   // start_req
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // scl, sda_out, sda_drive, busy_res, done_res, nack, pad
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);

    logic [7:0]            device_address_reg;
    logic [15:0]           unit_ticks_reg;
    logic                  m_tvalid_reg;
    logic [7:0]            m_tdata_reg;
    logic                  step;
    sccbwm_pkg::tick_res_t res;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign step     = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_address_reg <= sccbwm_pkg::DEVICE_ADDRESS_RST;
            unit_ticks_reg     <= sccbwm_pkg::UNIT_TICKS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                sccbwm_pkg::CFG_DEVICE_ADDRESS: device_address_reg <= cfg_wdata[7:0];
                default:                        unit_ticks_reg     <= cfg_wdata;
            endcase
        end
    end

    sccbwm_seq u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (step),
        .start_req      (s_tuser),
        .reg_addr       (s_tdata[7:0]),
        .reg_data       (s_tdata[15:8]),
        .sda_in         (s_tdata[16]),
        .device_address (device_address_reg),
        .unit_ticks     (unit_ticks_reg),
        .res            (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (step) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            m_tdata_reg <= {2'b00, res.nack, res.done_res, res.busy_res,
                            res.sda_drive, res.sda_out, res.scl};
        end
    end

endmodule

// ===== design/sccbwm_seq.sv =====
// ----------------------------------------------------------------------------
// SCCB write master sequencer
// Phase state machine; advances one tick per step and gives that tick's pins.
// ----------------------------------------------------------------------------
module sccbwm_seq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic                 start_req,
    input  logic [7:0]           reg_addr,
    input  logic [7:0]           reg_data,
    input  logic                 sda_in,
    input  logic [7:0]           device_address,
    input  logic [15:0]          unit_ticks,
    output sccbwm_pkg::tick_res_t res
);

    logic [sccbwm_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [3:0]  bit_index_reg, bit_index_next;
    logic [1:0]  byte_index_reg, byte_index_next;
    logic [15:0] tick_count_reg, tick_count_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic [7:0]  latched_addr_reg, latched_addr_next;
    logic [7:0]  latched_data_reg, latched_data_next;
    logic        nack_seen_reg, nack_seen_next;

    logic                           start_now;
    logic [sccbwm_pkg::PHASE_W-1:0] cur_phase;
    logic [3:0]                     cur_bit_index;
    logic [1:0]                     cur_byte_index;
    logic [15:0]                    cur_tick;
    logic [7:0]                     cur_shift;
    logic                           cur_nack;
    logic                           cur_bit;
    logic [16:0]                    tick_inc;
    logic                           unit_end;
    logic [1:0]                     nb_index;
    logic [7:0]                     nb_byte;

    assign start_now = (phase_reg == sccbwm_pkg::PH_IDLE) && start_req;

    assign cur_phase      = start_now ? sccbwm_pkg::PH_ST_HIGH : phase_reg;
    assign cur_bit_index  = start_now ? 4'd0 : bit_index_reg;
    assign cur_byte_index = start_now ? 2'd0 : byte_index_reg;
    assign cur_tick       = start_now ? 16'd0 : tick_count_reg;
    assign cur_shift      = start_now ? device_address : shift_byte_reg;
    assign cur_nack       = start_now ? 1'b0 : nack_seen_reg;

    assign cur_bit  = cur_shift[3'd7 - cur_bit_index[2:0]];
    assign tick_inc = {1'b0, cur_tick} + 17'd1;
    assign unit_end = tick_inc >= {1'b0, unit_ticks};

    // byte that follows the current one
    assign nb_index = cur_byte_index + 2'd1;
    always_comb begin
        case (nb_index)
            sccbwm_pkg::BYTE_DEV:  nb_byte = device_address;
            sccbwm_pkg::BYTE_ADDR: nb_byte = latched_addr_reg;
            default:               nb_byte = latched_data_reg;
        endcase
    end

    always_comb begin
        res               = '0;
        res.scl           = 1'b1;
        res.sda_out       = 1'b1;
        res.sda_drive     = 1'b1;
        res.busy_res      = 1'b1;
        phase_next        = cur_phase;
        bit_index_next    = cur_bit_index;
        byte_index_next   = cur_byte_index;
        tick_count_next   = cur_tick;
        shift_byte_next   = cur_shift;
        latched_addr_next = start_now ? reg_addr : latched_addr_reg;
        latched_data_next = start_now ? reg_data : latched_data_reg;
        nack_seen_next    = cur_nack;

        if (cur_phase == sccbwm_pkg::PH_IDLE ||
            cur_phase > sccbwm_pkg::PH_P_PAD) begin
            res.busy_res = 1'b0;
            phase_next   = sccbwm_pkg::PH_IDLE;
        end else begin
            unique case (cur_phase)
                sccbwm_pkg::PH_ST_HIGH: begin
                    res.scl = 1'b1; res.sda_out = 1'b1;
                end
                sccbwm_pkg::PH_ST_FALL: begin
                    res.scl = 1'b1; res.sda_out = 1'b0;
                end
                sccbwm_pkg::PH_ST_LOW, sccbwm_pkg::PH_ST_PAD,
                sccbwm_pkg::PH_P_LOW: begin
                    res.scl = 1'b0; res.sda_out = 1'b0;
                end
                sccbwm_pkg::PH_B_SET, sccbwm_pkg::PH_B_LOW: begin
                    res.scl = 1'b0; res.sda_out = cur_bit;
                end
                sccbwm_pkg::PH_B_HIGH: begin
                    res.scl = 1'b1; res.sda_out = cur_bit;
                end
                sccbwm_pkg::PH_A_SET, sccbwm_pkg::PH_A_LOW: begin
                    res.scl = 1'b0; res.sda_out = 1'b0; res.sda_drive = 1'b0;
                end
                sccbwm_pkg::PH_A_HIGH: begin
                    res.scl = 1'b1; res.sda_out = 1'b0; res.sda_drive = 1'b0;
                end
                sccbwm_pkg::PH_A_PAD, sccbwm_pkg::PH_END_PAD: begin
                    res.scl = 1'b0; res.sda_out = cur_shift[0];
                end
                sccbwm_pkg::PH_P_HIGH: begin
                    res.scl = 1'b1; res.sda_out = 1'b0;
                end
                default: begin
                    res.scl = 1'b1; res.sda_out = 1'b1;
                end
            endcase

            if (unit_end) begin
                tick_count_next = 16'd0;
                unique case (cur_phase)
                    sccbwm_pkg::PH_ST_HIGH: phase_next = sccbwm_pkg::PH_ST_FALL;
                    sccbwm_pkg::PH_ST_FALL: phase_next = sccbwm_pkg::PH_ST_LOW;
                    sccbwm_pkg::PH_ST_LOW:  phase_next = sccbwm_pkg::PH_ST_PAD;
                    sccbwm_pkg::PH_ST_PAD: begin
                        byte_index_next = sccbwm_pkg::BYTE_DEV;
                        shift_byte_next = device_address;
                        bit_index_next  = 4'd0;
                        phase_next      = sccbwm_pkg::PH_B_SET;
                    end
                    sccbwm_pkg::PH_B_SET:  phase_next = sccbwm_pkg::PH_B_HIGH;
                    sccbwm_pkg::PH_B_HIGH: phase_next = sccbwm_pkg::PH_B_LOW;
                    sccbwm_pkg::PH_B_LOW: begin
                        if (cur_bit_index >= sccbwm_pkg::LAST_BIT) begin
                            phase_next = sccbwm_pkg::PH_A_SET;
                        end else begin
                            bit_index_next = cur_bit_index + 4'd1;
                            phase_next     = sccbwm_pkg::PH_B_SET;
                        end
                    end
                    sccbwm_pkg::PH_A_SET: phase_next = sccbwm_pkg::PH_A_HIGH;
                    sccbwm_pkg::PH_A_HIGH: begin
                        if (sda_in) begin
                            nack_seen_next = 1'b1;
                            bit_index_next = sccbwm_pkg::NACKED_MARK;
                        end else begin
                            bit_index_next = sccbwm_pkg::ACKED_MARK;
                        end
                        phase_next = sccbwm_pkg::PH_A_LOW;
                    end
                    sccbwm_pkg::PH_A_LOW, sccbwm_pkg::PH_A_PAD: begin
                        if (cur_phase == sccbwm_pkg::PH_A_LOW &&
                            cur_bit_index == sccbwm_pkg::ACKED_MARK) begin
                            phase_next = sccbwm_pkg::PH_A_PAD;
                        end else if (cur_byte_index >= sccbwm_pkg::BYTE_DATA) begin
                            phase_next = sccbwm_pkg::PH_END_PAD;
                        end else begin
                            byte_index_next = nb_index;
                            shift_byte_next = nb_byte;
                            bit_index_next  = 4'd0;
                            phase_next      = sccbwm_pkg::PH_B_SET;
                        end
                    end
                    sccbwm_pkg::PH_END_PAD: phase_next = sccbwm_pkg::PH_P_LOW;
                    sccbwm_pkg::PH_P_LOW:   phase_next = sccbwm_pkg::PH_P_HIGH;
                    sccbwm_pkg::PH_P_HIGH:  phase_next = sccbwm_pkg::PH_P_RISE;
                    sccbwm_pkg::PH_P_RISE:  phase_next = sccbwm_pkg::PH_P_PAD;
                    default: begin
                        res.done_res = 1'b1;
                        res.nack     = cur_nack;
                        phase_next   = sccbwm_pkg::PH_IDLE;
                    end
                endcase
            end else begin
                tick_count_next = tick_inc[15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= sccbwm_pkg::PH_IDLE;
            bit_index_reg    <= '0;
            byte_index_reg   <= '0;
            tick_count_reg   <= '0;
            shift_byte_reg   <= '0;
            latched_addr_reg <= '0;
            latched_data_reg <= '0;
            nack_seen_reg    <= 1'b0;
        end else if (step) begin
            phase_reg        <= phase_next;
            bit_index_reg    <= bit_index_next;
            byte_index_reg   <= byte_index_next;
            tick_count_reg   <= tick_count_next;
            shift_byte_reg   <= shift_byte_next;
            latched_addr_reg <= latched_addr_next;
            latched_data_reg <= latched_data_next;
            nack_seen_reg    <= nack_seen_next;
        end
    end

endmodule
